// File: rtl/csc_pkg.sv
// Package of the CORDIC sine and cosine unit: formats, angle limits and constant tables.
package csc_pkg;

  // Angle and result formats, fixed by the stream fields.
  localparam int unsigned IN_FRAC_BITS = 7;
  localparam int unsigned IN_INT_BITS = 8;
  localparam int unsigned IN_W = 1 + IN_INT_BITS + IN_FRAC_BITS;
  localparam int unsigned OUT_W = IN_FRAC_BITS + 2;
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // Defaults of the top-level parameters, and the length of the angle table.
  localparam int unsigned DEF_ITERATIONS = 17;
  localparam int unsigned DEF_WORK_FRAC_BITS = 16;
  localparam int unsigned TABLE_LEN = 24;

  // Angle limits and unity in the input format.
  localparam logic signed [IN_W:0] LIM180 = (IN_W + 1)'(180 << IN_FRAC_BITS);
  localparam logic signed [IN_W:0] LIM90 = (IN_W + 1)'(90 << IN_FRAC_BITS);
  localparam int unsigned UNITY = 1 << IN_FRAC_BITS;

  // Constants in units of 1e-12.
  localparam logic [127:0] PICO = 128'd1000000000000;
  localparam logic [63:0] GAIN_PICO = 64'd607252935009;

  // atan(2^-i) in degrees, in units of 1e-12 degree.
  localparam logic [63:0] ATAN_PICO [TABLE_LEN] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
    64'd3576334374997, 64'd1789910608246, 64'd895173710211, 64'd447614170861,
    64'd223810500369, 64'd111905677066, 64'd55952891894, 64'd27976452617,
    64'd13988227142, 64'd6994113675, 64'd3497056851, 64'd1748528427,
    64'd874264214, 64'd437132107, 64'd218566053, 64'd109283027,
    64'd54641513, 64'd27320757, 64'd13660378, 64'd6830189
  };

  // Rounds a value in units of 1e-12 to nearest at the given number of fraction bits.
  // Used at elaboration only.
  function automatic logic [63:0] pico_to_work(input logic [63:0] v, input int unsigned frac);
    logic [127:0] t;
    t = {64'd0, v} << frac;
    t = (t + PICO / 2) / PICO;
    return t[63:0];
  endfunction

  // Fold signs that travel with each word down the pipeline.
  typedef struct packed {
    logic neg_cos;
    logic neg_sin;
  } csc_flags_t;

endpackage

// File: rtl/cordic_sin_cos_degrees_unit.sv
// Top level of the pipelined CORDIC sine and cosine unit for angles in degrees.
// An accepted angle passes one fold register, one register per CORDIC iteration and
// one output register on its way to its result word. Throughput: one word per cycle
// while the output is not stalled; each iteration has its own shift-add stage.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
// Reset is asynchronous, active low, and clears the valid bits of every stage only.
module cordic_sin_cos_degrees_unit
  import csc_pkg::*;
#(
  parameter int unsigned ITERATIONS = DEF_ITERATIONS,
  parameter int unsigned WORK_FRAC_BITS = DEF_WORK_FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] angle_deg
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [8:0] cosine, [17:9] sine, rest zero
);

  // The work format carries WORK_FRAC_BITS fraction bits. The residual angle needs
  // room for about +-100 degrees, the vector components for a little more than one.
  localparam int unsigned XW = WORK_FRAC_BITS + 3;
  localparam int unsigned ZW = WORK_FRAC_BITS + 9;
  localparam int unsigned SH = WORK_FRAC_BITS - IN_FRAC_BITS;
  localparam logic [63:0] GAIN_RAW = pico_to_work(GAIN_PICO, WORK_FRAC_BITS);
  localparam logic signed [XW-1:0] X_START = XW'(GAIN_RAW);
  localparam logic signed [XW-1:0] RND = XW'((1 << SH) - 1);
  localparam logic signed [XW-1:0] UNITY_X = XW'(UNITY);
  localparam logic signed [OUT_W-1:0] UNITY_OUT = OUT_W'(UNITY);
  localparam logic signed [ZW-1:0] Z90 = ZW'(LIM90) <<< SH;
  localparam int unsigned PAD_W = OUT_TDATA_W - 2 * OUT_W;

  // The pipeline advances whenever the output register is empty or being drained.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Fold stage: clamp to +-180 degrees, then fold into +-90 degrees. The fold
  // signs are kept aside and applied once after the last iteration.
  logic signed [IN_W:0]  ang_in, ang_clip, ang_fold;
  csc_flags_t            fold_flags;

  assign ang_in = (IN_W + 1)'($signed(s_axis_tdata[IN_W-1:0]));

  always_comb begin
    if (ang_in > LIM180) begin
      ang_clip = LIM180;
    end else if (ang_in < -LIM180) begin
      ang_clip = -LIM180;
    end else begin
      ang_clip = ang_in;
    end
    fold_flags = '0;
    if (ang_clip > LIM90) begin
      ang_fold = LIM180 - ang_clip;
      fold_flags.neg_cos = 1'b1;
    end else if (ang_clip < -LIM90) begin
      ang_fold = LIM180 + ang_clip;
      fold_flags.neg_cos = 1'b1;
      fold_flags.neg_sin = 1'b1;
    end else begin
      ang_fold = ang_clip;
    end
  end

  // Stage signals: index 0 is the fold register, index k + 1 follows iteration k.
  logic                 vld_w   [ITERATIONS+1];
  logic signed [XW-1:0] x_w     [ITERATIONS+1];
  logic signed [XW-1:0] y_w     [ITERATIONS+1];
  logic signed [ZW-1:0] z_w     [ITERATIONS+1];
  csc_flags_t           flags_w [ITERATIONS+1];

  logic                 fold_vld_q;
  logic signed [ZW-1:0] fold_z_q;
  csc_flags_t           fold_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
    end else if (en) begin
      fold_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fold_z_q     <= ZW'(ang_fold) <<< SH;
      fold_flags_q <= fold_flags;
    end
  end

  // Every word starts from the vector (K, 0).
  assign vld_w[0]   = fold_vld_q;
  assign x_w[0]     = X_START;
  assign y_w[0]     = '0;
  assign z_w[0]     = fold_z_q;
  assign flags_w[0] = fold_flags_q;

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    csc_iter #(
      .STAGE          (k),
      .WORK_FRAC_BITS (WORK_FRAC_BITS)
    ) u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .vld_i   (vld_w[k]),
      .x_i     (x_w[k]),
      .y_i     (y_w[k]),
      .z_i     (z_w[k]),
      .flags_i (flags_w[k]),
      .vld_o   (vld_w[k+1]),
      .x_o     (x_w[k+1]),
      .y_o     (y_w[k+1]),
      .z_o     (z_w[k+1]),
      .flags_o (flags_w[k+1])
    );
  end

  // Output stage: apply the fold signs, truncate toward zero to the result
  // format and saturate to +-1.0.
  logic signed [XW-1:0]    cos_n, sin_n, cos_t, sin_t, cos_s, sin_s;
  logic signed [OUT_W-1:0] cos_q, sin_q;
  logic                    out_vld_q;

  assign cos_n = flags_w[ITERATIONS].neg_cos ? -x_w[ITERATIONS] : x_w[ITERATIONS];
  assign sin_n = flags_w[ITERATIONS].neg_sin ? -y_w[ITERATIONS] : y_w[ITERATIONS];
  assign cos_t = cos_n[XW-1] ? ((cos_n + RND) >>> SH) : (cos_n >>> SH);
  assign sin_t = sin_n[XW-1] ? ((sin_n + RND) >>> SH) : (sin_n >>> SH);

  always_comb begin
    if (cos_t > UNITY_X) begin
      cos_s = UNITY_X;
    end else if (cos_t < -UNITY_X) begin
      cos_s = -UNITY_X;
    end else begin
      cos_s = cos_t;
    end
    if (sin_t > UNITY_X) begin
      sin_s = UNITY_X;
    end else if (sin_t < -UNITY_X) begin
      sin_s = -UNITY_X;
    end else begin
      sin_s = sin_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_w[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_q <= cos_s[OUT_W-1:0];
      sin_q <= sin_s[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {PAD_W'(0), sin_q, cos_q};

`ifndef ASSERT_OFF
  // The saturation keeps both results within +-1.0.
  a_cos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cos_q <= UNITY_OUT && cos_q >= -UNITY_OUT))
    else $error("cosine beyond unity");
  a_sin_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sin_q <= UNITY_OUT && sin_q >= -UNITY_OUT))
    else $error("sine beyond unity");
  // The fold leaves a residual angle within +-90 degrees.
  a_fold_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_vld_q |-> (fold_z_q <= Z90 && fold_z_q >= -Z90))
    else $error("folded angle beyond ninety degrees");
  // A stall freezes the first stage together with the last iteration stage.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(fold_vld_q) && $stable(vld_w[ITERATIONS])))
    else $error("pipeline moved during a stall");
`endif

endmodule

// File: rtl/csc_iter.sv
// One CORDIC rotation iteration with its pipeline register.
module csc_iter
  import csc_pkg::*;
#(
  parameter int unsigned STAGE = 0,
  parameter int unsigned WORK_FRAC_BITS = DEF_WORK_FRAC_BITS,
  localparam int unsigned XW = WORK_FRAC_BITS + 3,
  localparam int unsigned ZW = WORK_FRAC_BITS + 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  csc_flags_t           flags_i,
  output logic                 vld_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output csc_flags_t           flags_o
);

  localparam logic [63:0] DA_RAW = pico_to_work(ATAN_PICO[STAGE], WORK_FRAC_BITS);
  localparam logic signed [ZW-1:0] DA = ZW'(DA_RAW);

  logic signed [XW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  csc_flags_t           flags_q;
  logic                 vld_q;

  assign dx = x_i >>> STAGE;
  assign dy = y_i >>> STAGE;

  // A zero residual rotates in the positive direction.
  always_comb begin
    if (z_i[ZW-1]) begin
      x_d = x_i + dy;
      y_d = y_i - dx;
      z_d = z_i + DA;
    end else begin
      x_d = x_i - dy;
      y_d = y_i + dx;
      z_d = z_i - DA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      flags_q <= flags_i;
    end
  end

  assign vld_o   = vld_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign flags_o = flags_q;

endmodule

// File: tb/tb_cordic_sin_cos_degrees_unit.sv
// Self-checking testbench of the CORDIC sine and cosine unit for angles in degrees.
`timescale 1ns / 1ps

module tb_cordic_sin_cos_degrees_unit;
  import csc_pkg::*;

  // The unit is built with its default depth and working precision. The
  // predictor below is written for the same values.
  localparam int unsigned STAGES = DEF_ITERATIONS;
  localparam int unsigned WORK_FRAC = DEF_WORK_FRAC_BITS;
  localparam int unsigned FRAC_SHIFT = WORK_FRAC - IN_FRAC_BITS;
  localparam int unsigned LATENCY = STAGES + 2;
  localparam int unsigned N_DIRECTED = 24;
  localparam int unsigned N_RANDOM = 1700;
  localparam int unsigned DRAIN_AT = 600;
  localparam longint ANGLE_180 = 180 << IN_FRAC_BITS;
  localparam longint ANGLE_90 = 90 << IN_FRAC_BITS;
  localparam longint ONE_OUT = 1 << IN_FRAC_BITS;
  localparam longint unsigned PICO_ONE = 64'd1000000000000;

  // One result word split into its fields.
  typedef struct packed {
    logic [OUT_TDATA_W-2*OUT_W-1:0] pad;
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } trig_word_t;

  // One row of the directed table. A field marked as known is compared with
  // the value typed in the row; all other fields come from the predictor.
  typedef struct {
    logic [IN_W-1:0] angle;
    bit cos_known;
    logic signed [OUT_W-1:0] cos_val;
    bit sin_known;
    logic signed [OUT_W-1:0] sin_val;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;   // [15:0] angle_deg
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [8:0] cosine, [17:9] sine, rest zero

  // Expected result words, oldest first.
  trig_word_t pending_results[$];
  int unsigned mismatches = 0;
  // When set, neither side inserts any idle cycles.
  bit steady = 1'b0;
  int unsigned ready_hold = 0;

  // CORDIC constants in the working format, rounded to nearest.
  longint gain_work;
  longint atan_work[STAGES];
  directed_row_t directed_rows[N_DIRECTED];

  cordic_sin_cos_degrees_unit #(
    .ITERATIONS(STAGES),
    .WORK_FRAC_BITS(WORK_FRAC)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Scales a constant given in units of 1e-12 to the working format and
  // rounds it to nearest. The remainder part cannot overflow 64 bits.
  function automatic longint round_pico(input longint unsigned v);
    longint unsigned whole;
    longint unsigned rest;
    whole = v / PICO_ONE;
    rest = v % PICO_ONE;
    return longint'((whole << WORK_FRAC) + ((rest << WORK_FRAC) + PICO_ONE / 2) / PICO_ONE);
  endfunction

  function automatic void load_cordic_constants();
    longint unsigned atan_in_pico[24];
    atan_in_pico = '{
      64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
      64'd3576334374997, 64'd1789910608246, 64'd895173710211, 64'd447614170861,
      64'd223810500369, 64'd111905677066, 64'd55952891894, 64'd27976452617,
      64'd13988227142, 64'd6994113675, 64'd3497056851, 64'd1748528427,
      64'd874264214, 64'd437132107, 64'd218566053, 64'd109283027,
      64'd54641513, 64'd27320757, 64'd13660378, 64'd6830189
    };
    gain_work = round_pico(64'd607252935009);
    for (int i = 0; i < STAGES; i++) begin
      atan_work[i] = round_pico(atan_in_pico[i]);
    end
  endfunction

  // Works out the cosine and sine word that the unit gives for one angle.
  function automatic trig_word_t predict_trig(input logic [IN_W-1:0] angle);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    bit flip_cos;
    bit flip_sin;
    trig_word_t w;
    a = longint'($signed(angle));
    flip_cos = 1'b0;
    flip_sin = 1'b0;
    // Angles beyond half a turn either way saturate.
    if (a > ANGLE_180) a = ANGLE_180;
    if (a < -ANGLE_180) a = -ANGLE_180;
    // Fold into the right half plane; the signs are fixed up at the end.
    if (a > ANGLE_90) begin
      a = ANGLE_180 - a;
      flip_cos = 1'b1;
    end else if (a < -ANGLE_90) begin
      a = ANGLE_180 + a;
      flip_cos = 1'b1;
      flip_sin = 1'b1;
    end
    z = a <<< FRAC_SHIFT;
    x = gain_work;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      // A residual of exactly zero rotates the positive way.
      if (z < 0) begin
        x = x + dy;
        y = y - dx;
        z = z + atan_work[i];
      end else begin
        x = x - dy;
        y = y + dx;
        z = z - atan_work[i];
      end
    end
    if (flip_cos) x = -x;
    if (flip_sin) y = -y;
    // Signed division truncates toward zero, as the unit does.
    c = x / (64'sd1 <<< FRAC_SHIFT);
    s = y / (64'sd1 <<< FRAC_SHIFT);
    if (c > ONE_OUT) c = ONE_OUT;
    if (c < -ONE_OUT) c = -ONE_OUT;
    if (s > ONE_OUT) s = ONE_OUT;
    if (s < -ONE_OUT) s = -ONE_OUT;
    w.pad = '0;
    w.cosine = c[OUT_W-1:0];
    w.sine = s[OUT_W-1:0];
    return w;
  endfunction

  // Idle length for either side: mostly none, sometimes a few cycles, rarely long.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random angle: mostly inside the legal range, some clustered around the
  // fold points and zero, and some anywhere in the 16-bit field so that the
  // saturation path and every input bit get exercised.
  function automatic logic [IN_W-1:0] pick_angle();
    int unsigned r;
    int v;
    int anchors[5];
    anchors = '{0, 11520, -11520, 23040, -23040};
    r = $urandom_range(99);
    if (r < 70) begin
      v = int'($urandom_range(46080)) - 23040;
    end else if (r < 85) begin
      v = anchors[$urandom_range(4)] + int'($urandom_range(8)) - 4;
    end else begin
      v = int'($urandom_range(16'hffff));
    end
    return v[IN_W-1:0];
  endfunction

  // Presents one angle word after a random gap, waits for the handshake,
  // and queues the word that the unit must give back for it. Known fields
  // of a directed row override the predicted ones.
  task automatic send_angle(input directed_row_t row);
    int unsigned gap;
    trig_word_t want;
    gap = pick_idle();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= IN_TDATA_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(row.angle);
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_trig(row.angle);
    if (row.cos_known) want.cosine = row.cos_val;
    if (row.sin_known) want.sine = row.sin_val;
    pending_results.push_back(want);
  endtask

  // Output side: the ready line stalls in random runs. It is driven from the
  // first edge on, reset included.
  initial m_axis_tready = 1'b0;
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      m_axis_tready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      ready_hold = pick_idle();
      m_axis_tready <= (ready_hold == 0);
      if (ready_hold != 0) ready_hold = ready_hold - 1;
    end
  end

  // Result checker: every word taken from the unit is compared, field by
  // field, with the oldest expectation.
  always @(posedge clk_i) begin
    trig_word_t got;
    trig_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, got cosine %0d sine %0d",
                 $time, got.cosine, got.sine);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.cosine !== want.cosine) begin
          $display("%0t: cosine: expected %0d, got %0d", $time, want.cosine, got.cosine);
          mismatches++;
        end
        if (got.sine !== want.sine) begin
          $display("%0t: sine: expected %0d, got %0d", $time, want.sine, got.sine);
          mismatches++;
        end
        if (got.pad !== want.pad) begin
          $display("%0t: padding bits: expected %0h, got %0h", $time, want.pad, got.pad);
          mismatches++;
        end
      end
    end
  end

  // Hard limit on the run, far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    directed_row_t row;
    int unsigned settle;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    load_cordic_constants();

    // Directed part: zero, the fold points and their neighbors, half a turn
    // either way, saturation at both ends of the field, a residual that hits
    // zero exactly (45 degrees), and a few common angles. The sine of zero
    // and the cosine of a quarter turn are exactly zero after truncation.
    directed_rows = '{
      '{16'sd0, 1'b0, 9'sd0, 1'b1, 9'sd0},
      '{16'sd1, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{-16'sd1, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'sd11520, 1'b1, 9'sd0, 1'b0, 9'sd0},
      '{16'sd11519, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'sd11521, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{-16'sd11520, 1'b1, 9'sd0, 1'b0, 9'sd0},
      '{-16'sd11519, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{-16'sd11521, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'sd23040, 1'b0, 9'sd0, 1'b1, 9'sd0},
      '{16'sd23039, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{-16'sd23040, 1'b0, 9'sd0, 1'b1, 9'sd0},
      '{-16'sd23039, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'sd23041, 1'b0, 9'sd0, 1'b1, 9'sd0},
      '{-16'sd23041, 1'b0, 9'sd0, 1'b1, 9'sd0},
      '{16'sd32767, 1'b0, 9'sd0, 1'b1, 9'sd0},
      '{-16'sd32768, 1'b0, 9'sd0, 1'b1, 9'sd0},
      '{16'sd5760, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{-16'sd5760, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'sd3840, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'sd7680, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'sd15360, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{-16'sd15360, 1'b0, 9'sd0, 1'b0, 9'sd0},
      '{16'h5555, 1'b0, 9'sd0, 1'b0, 9'sd0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_angle(directed_rows[i]);

    // Random part. Every hundred words the run may switch to a stretch with
    // no idle cycles on either side, so the pipeline also runs at full rate.
    row.cos_known = 1'b0;
    row.sin_known = 1'b0;
    row.cos_val = '0;
    row.sin_val = '0;
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) steady = ($urandom_range(3) == 0);
      if (n == DRAIN_AT) begin
        // Hold the input back until every outstanding word has come out.
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      row.angle = pick_angle();
      send_angle(row);
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    // Let a stray extra word surface if the unit makes one.
    settle = 4 * LATENCY;
    repeat (settle) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
